>>> hw/rtl/text_command_request_tokenizer_macros.svh
`ifndef TEXT_COMMAND_REQUEST_TOKENIZER_MACROS_SVH
`define TEXT_COMMAND_REQUEST_TOKENIZER_MACROS_SVH

// Same-cycle check: whenever pre holds, cond must hold too.
`define TCRT_ASSERT(label, pre, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (cond)) \
    else $error(msg);

// Next-cycle check: whenever pre holds, cond must hold in the next cycle.
`define TCRT_ASSERT_NEXT(label, pre, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (cond)) \
    else $error(msg);

`endif

>>> hw/rtl/tcrt_pkg.sv
`default_nettype none

package tcrt_pkg;

  // Fixed register and field widths
  localparam int CMD_SLOTS = 4;
  localparam int NAME_W    = 64;
  localparam int COUNTS_W  = 12;
  localparam int CCOUNT_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int SPAN_W    = 12;

  // Parameter defaults
  localparam int DEF_NUM_COMMANDS      = 4;
  localparam int DEF_NAME_BYTES        = 8;
  localparam int DEF_MAX_PARAMS        = 7;
  localparam int DEF_MAX_REQUEST_BYTES = 4096;

  // Queue depths
  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NAME_0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_3       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_COUNTS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_COUNT    = 3'd5;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNKNOWN     = 2'd1;
  localparam logic [1:0] ST_WRONG_COUNT = 2'd2;
  localparam logic [1:0] ST_TOO_LONG    = 2'd3;

  // Result kinds
  localparam logic KIND_SPAN   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Parser phases
  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_WORD   = 6'b000010,
    PH_GAP    = 6'b000100,
    PH_BARE   = 6'b001000,
    PH_QUOTED = 6'b010000,
    PH_SINK   = 6'b100000
  } phase_t;

  // Classified request byte
  typedef struct packed {
    logic [7:0] code;
    logic       is_space;
    logic       is_quote;
    logic       is_end;
  } cls_t;

  // One result word
  typedef struct packed {
    logic              kind;
    logic [2:0]        param_index;
    logic [SPAN_W-1:0] param_start;
    logic [SPAN_W-1:0] param_length;
    logic [1:0]        status;
    logic [1:0]        command;
    logic              last;
  } res_t;

  // Queue fill status
  typedef struct packed {
    logic valid;  // at least one entry
    logic room1;  // space for one more
    logic room2;  // space for two more
  } fifo_stat_t;

  // Configuration registers
  typedef struct packed {
    logic [CMD_SLOTS-1:0][NAME_W-1:0] name;
    logic [COUNTS_W-1:0]              param_counts;
    logic [CCOUNT_W-1:0]              count;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/text_command_request_tokenizer.sv
`default_nettype none

// A byte accepted into the input queue is parsed from there, and its result word is registered in the output queue.
// Throughput: one byte per cycle while the output queue has room, set by the single-step parser in the back end.
// A terminator that closes a bare parameter gives two words, drained one per cycle while out_ready is high.
// The parser waits while the output queue has room for fewer than two words.
// Reset (rst, synchronous): parser to whitespace skip, queues empty, command table zero.

module text_command_request_tokenizer #(
  parameter int NUM_COMMANDS      = tcrt_pkg::DEF_NUM_COMMANDS,
  parameter int NAME_BYTES        = tcrt_pkg::DEF_NAME_BYTES,
  parameter int MAX_PARAMS        = tcrt_pkg::DEF_MAX_PARAMS,
  parameter int MAX_REQUEST_BYTES = tcrt_pkg::DEF_MAX_REQUEST_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tcrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcrt_pkg::NAME_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     char_code,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                kind,
  output logic [2:0]                          param_index,
  output logic [tcrt_pkg::SPAN_W-1:0]         param_start,
  output logic [tcrt_pkg::SPAN_W-1:0]         param_length,
  output logic [1:0]                          status,
  output logic [1:0]                          command,
  output logic                                last
);

  tcrt_pkg::cls_t       cur;
  tcrt_pkg::fifo_stat_t in_stat;
  tcrt_pkg::fifo_stat_t out_stat;
  logic                 pop;
  logic                 push_a;
  logic                 push_b;
  tcrt_pkg::res_t       word_a;
  tcrt_pkg::res_t       word_b;
  logic [$bits(tcrt_pkg::res_t)-1:0] out_raw;
  tcrt_pkg::res_t       out_word;
  logic                 out_pop;

  tcrt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .pop       (pop),
    .cls_out   (cur),
    .stat      (in_stat)
  );

  tcrt_back #(
    .NUM_COMMANDS      (NUM_COMMANDS),
    .NAME_BYTES        (NAME_BYTES),
    .MAX_PARAMS        (MAX_PARAMS),
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cur       (cur),
    .in_stat   (in_stat),
    .out_stat  (out_stat),
    .pop       (pop),
    .push_a    (push_a),
    .word_a    (word_a),
    .push_b    (push_b),
    .word_b    (word_b)
  );

  // Result queue toward the output port
  tcrt_fifo #(
    .WIDTH ($bits(tcrt_pkg::res_t)),
    .DEPTH (tcrt_pkg::OUT_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst      (rst),
    .push_a   (push_a),
    .data_a   (word_a),
    .push_b   (push_b),
    .data_b   (word_b),
    .pop      (out_pop),
    .data_out (out_raw),
    .stat     (out_stat)
  );

  assign out_word     = tcrt_pkg::res_t'(out_raw);
  assign out_valid    = out_stat.valid;
  assign out_pop      = out_valid && out_ready;
  assign kind         = out_word.kind;
  assign param_index  = out_word.param_index;
  assign param_start  = out_word.param_start;
  assign param_length = out_word.param_length;
  assign status       = out_word.status;
  assign command      = out_word.command;
  assign last         = out_word.last;

endmodule

`default_nettype wire

>>> hw/rtl/tcrt_fifo.sv
`default_nettype none

// Small show-ahead queue; takes up to two words a cycle, gives one.
module tcrt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_a,
  input  wire logic [WIDTH-1:0] data_a,
  input  wire logic             push_b,
  input  wire logic [WIDTH-1:0] data_b,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] data_out,
  output tcrt_pkg::fifo_stat_t  stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [AW-1:0]    wr_ptr_next;
  logic [AW-1:0]    wr_ptr_b;

  assign wr_ptr_b = AW'(wr_ptr + 1'b1);

  // Storage; lane b lands right after lane a
  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= data_a;
    end
    if (push_b) begin
      mem[wr_ptr_b] <= data_b;
    end
  end

  always_comb begin
    count_next  = CW'(count + CW'(push_a) + CW'(push_b) - CW'(pop));
    wr_ptr_next = AW'(wr_ptr + AW'(push_a) + AW'(push_b));
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) begin
        rd_ptr <= AW'(rd_ptr + 1'b1);
      end
      count <= count_next;
    end
  end

  assign data_out   = mem[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.room1 = (count < CW'(DEPTH));
  assign stat.room2 = (count <= CW'(DEPTH - 2));

endmodule

`default_nettype wire

>>> hw/rtl/tcrt_front.sv
`default_nettype none

// Front end: accepts request bytes, tags their class, queues them.
module tcrt_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       char_code,
  input  wire logic             pop,
  output tcrt_pkg::cls_t        cls_out,
  output tcrt_pkg::fifo_stat_t  stat
);

  tcrt_pkg::cls_t cls_in;
  logic           push;
  logic [$bits(tcrt_pkg::cls_t)-1:0] q_out;

  // Byte classification
  always_comb begin
    cls_in.code     = char_code;
    cls_in.is_space = (char_code == tcrt_pkg::CH_SPACE) || (char_code == tcrt_pkg::CH_TAB) ||
                      (char_code == tcrt_pkg::CH_CR)    || (char_code == tcrt_pkg::CH_LF);
    cls_in.is_quote = (char_code == tcrt_pkg::CH_QUOTE);
    cls_in.is_end   = (char_code == tcrt_pkg::CH_NUL);
  end

  assign in_ready = stat.room1;
  assign push     = in_valid && in_ready;

  tcrt_fifo #(
    .WIDTH ($bits(tcrt_pkg::cls_t)),
    .DEPTH (tcrt_pkg::IN_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_a   (push),
    .data_a   (cls_in),
    .push_b   (1'b0),
    .data_b   ('0),
    .pop      (pop),
    .data_out (q_out),
    .stat     (stat)
  );

  assign cls_out = tcrt_pkg::cls_t'(q_out);

endmodule

`default_nettype wire

>>> hw/rtl/tcrt_back.sv
`default_nettype none

`include "text_command_request_tokenizer_macros.svh"

// Back end: command table, parser state machine and result words.
module tcrt_back #(
  parameter int NUM_COMMANDS      = tcrt_pkg::DEF_NUM_COMMANDS,
  parameter int NAME_BYTES        = tcrt_pkg::DEF_NAME_BYTES,
  parameter int MAX_PARAMS        = tcrt_pkg::DEF_MAX_PARAMS,
  parameter int MAX_REQUEST_BYTES = tcrt_pkg::DEF_MAX_REQUEST_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tcrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcrt_pkg::NAME_W-1:0]    cfg_data,
  input  wire tcrt_pkg::cls_t                 cur,
  input  wire tcrt_pkg::fifo_stat_t           in_stat,
  input  wire tcrt_pkg::fifo_stat_t           out_stat,
  output logic                                pop,
  output logic                                push_a,
  output tcrt_pkg::res_t                      word_a,
  output logic                                push_b,
  output tcrt_pkg::res_t                      word_b
);

  localparam int OFF_W = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int NP_W  = $clog2(NAME_BYTES + 1);

  tcrt_pkg::cfg_t cfg;

  tcrt_pkg::phase_t        phase, phase_next;
  logic [OFF_W-1:0]        byte_offset, byte_offset_next;
  logic [OFF_W-1:0]        token_start, token_start_next;
  logic [NP_W-1:0]         name_position, name_position_next;
  logic [NUM_COMMANDS-1:0] match_flags, match_flags_next;
  logic [1:0]              chosen_command, chosen_command_next;
  logic [2:0]              params_done, params_done_next;
  logic [1:0]              error_code, error_code_next;

  logic                    step;
  logic [7:0]              name_byte [NUM_COMMANDS];
  logic [NUM_COMMANDS-1:0] mismatch;
  logic [NUM_COMMANDS-1:0] hit;
  logic                    any_hit;
  logic [1:0]              pick;
  logic                    pos_full;
  logic [2:0]              active;
  logic [2:0]              req_tab [tcrt_pkg::CMD_SLOTS];
  logic [2:0]              req_cur;
  logic [OFF_W-1:0]        span_len;
  logic                    too_long;
  logic [1:0]              end_err;
  logic [1:0]              end_cmd;
  tcrt_pkg::res_t          span_w;
  tcrt_pkg::res_t          stat_w;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcrt_pkg::REG_NAME_0:       cfg.name[0] <= cfg_data;
        tcrt_pkg::REG_NAME_1:       cfg.name[1] <= cfg_data;
        tcrt_pkg::REG_NAME_2:       cfg.name[2] <= cfg_data;
        tcrt_pkg::REG_NAME_3:       cfg.name[3] <= cfg_data;
        tcrt_pkg::REG_PARAM_COUNTS: cfg.param_counts <= cfg_data[tcrt_pkg::COUNTS_W-1:0];
        tcrt_pkg::REG_CMD_COUNT:    cfg.count <= cfg_data[tcrt_pkg::CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Table decode: clamped counts, active entries
  always_comb begin
    for (int k = 0; k < tcrt_pkg::CMD_SLOTS; k++) begin
      req_tab[k] = (cfg.param_counts[3*k +: 3] > 3'(MAX_PARAMS)) ? 3'(MAX_PARAMS)
                                                                 : cfg.param_counts[3*k +: 3];
    end
    active  = (cfg.count > 3'(NUM_COMMANDS)) ? 3'(NUM_COMMANDS) : cfg.count;
    req_cur = req_tab[chosen_command];
  end

  // Name compare at the current word position
  always_comb begin
    pos_full = (name_position >= NP_W'(NAME_BYTES));
    for (int k = 0; k < NUM_COMMANDS; k++) begin
      name_byte[k] = cfg.name[k][{3'(name_position), 3'b000} +: 8];
      mismatch[k]  = (name_byte[k] != cur.code);
      hit[k]       = (3'(k) < active) && match_flags[k] &&
                     (pos_full || (name_byte[k] == tcrt_pkg::CH_NUL));
    end
    any_hit = |hit;
    pick    = '0;
    for (int k = NUM_COMMANDS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        pick = 2'(k);
      end
    end
  end

  assign step     = in_stat.valid && out_stat.room2;
  assign pop      = step;
  assign span_len = OFF_W'(byte_offset - token_start);
  assign too_long = (byte_offset >= OFF_W'(MAX_REQUEST_BYTES));

  // Span word for the parameter that closes now
  always_comb begin
    span_w              = '0;
    span_w.kind         = tcrt_pkg::KIND_SPAN;
    span_w.param_index  = params_done;
    span_w.param_start  = tcrt_pkg::SPAN_W'(token_start);
    span_w.param_length = tcrt_pkg::SPAN_W'(span_len);
    span_w.status       = tcrt_pkg::ST_OK;
    span_w.command      = chosen_command;
    span_w.last         = 1'b0;
  end

  // Terminator resolution
  always_comb begin
    end_err = error_code;
    end_cmd = chosen_command;
    unique case (phase)
      tcrt_pkg::PH_LEAD, tcrt_pkg::PH_WORD: begin
        if (!any_hit) begin
          end_err = tcrt_pkg::ST_UNKNOWN;
        end else begin
          end_cmd = pick;
          if (req_tab[pick] != 3'd0) begin
            end_err = tcrt_pkg::ST_WRONG_COUNT;
          end
        end
      end
      tcrt_pkg::PH_GAP: begin
        if (params_done < req_cur) begin
          end_err = tcrt_pkg::ST_WRONG_COUNT;
        end
      end
      tcrt_pkg::PH_BARE: begin
        // the closing span counts toward the total
        if ((4'(params_done) + 4'd1) < 4'(req_cur)) begin
          end_err = tcrt_pkg::ST_WRONG_COUNT;
        end
      end
      tcrt_pkg::PH_QUOTED: begin
        end_err = tcrt_pkg::ST_WRONG_COUNT;
      end
      tcrt_pkg::PH_SINK: ;
      default: ;
    endcase
    stat_w         = '0;
    stat_w.kind    = tcrt_pkg::KIND_STATUS;
    stat_w.status  = end_err;
    stat_w.command = (end_err == tcrt_pkg::ST_OK) ? end_cmd : 2'd0;
    stat_w.last    = 1'b1;
  end

  // Parser next state and result words
  always_comb begin
    phase_next          = phase;
    byte_offset_next    = byte_offset;
    token_start_next    = token_start;
    name_position_next  = name_position;
    match_flags_next    = match_flags;
    chosen_command_next = chosen_command;
    params_done_next    = params_done;
    error_code_next     = error_code;
    push_a              = 1'b0;
    push_b              = 1'b0;
    word_a              = stat_w;
    word_b              = stat_w;

    if (step && cur.is_end) begin
      // final word, optionally preceded by a closing bare span
      if (phase == tcrt_pkg::PH_BARE) begin
        push_a = 1'b1;
        word_a = span_w;
        push_b = 1'b1;
      end else begin
        push_a = 1'b1;
      end
      phase_next          = tcrt_pkg::PH_LEAD;
      byte_offset_next    = '0;
      token_start_next    = '0;
      name_position_next  = '0;
      match_flags_next    = '1;
      chosen_command_next = '0;
      params_done_next    = '0;
      error_code_next     = tcrt_pkg::ST_OK;
    end else if (step) begin
      if (phase != tcrt_pkg::PH_SINK && too_long) begin
        error_code_next = tcrt_pkg::ST_TOO_LONG;
        phase_next      = tcrt_pkg::PH_SINK;
      end else begin
        unique case (phase)
          tcrt_pkg::PH_LEAD, tcrt_pkg::PH_WORD: begin
            if (!cur.is_space) begin
              phase_next = tcrt_pkg::PH_WORD;
              if (pos_full) begin
                match_flags_next = '0;
              end else begin
                match_flags_next   = match_flags & ~mismatch;
                name_position_next = NP_W'(name_position + 1'b1);
              end
            end else if (phase == tcrt_pkg::PH_WORD) begin
              if (any_hit) begin
                chosen_command_next = pick;
                phase_next          = tcrt_pkg::PH_GAP;
              end else begin
                error_code_next = tcrt_pkg::ST_UNKNOWN;
                phase_next      = tcrt_pkg::PH_SINK;
              end
            end
          end
          tcrt_pkg::PH_GAP: begin
            if (!cur.is_space) begin
              if (params_done >= req_cur) begin
                error_code_next = tcrt_pkg::ST_WRONG_COUNT;
                phase_next      = tcrt_pkg::PH_SINK;
              end else if (cur.is_quote) begin
                phase_next       = tcrt_pkg::PH_QUOTED;
                token_start_next = OFF_W'(byte_offset + 1'b1);
              end else begin
                phase_next       = tcrt_pkg::PH_BARE;
                token_start_next = byte_offset;
              end
            end
          end
          tcrt_pkg::PH_BARE: begin
            if (cur.is_space) begin
              push_a           = 1'b1;
              word_a           = span_w;
              params_done_next = 3'(params_done + 1'b1);
              phase_next       = tcrt_pkg::PH_GAP;
            end
          end
          tcrt_pkg::PH_QUOTED: begin
            if (cur.is_quote) begin
              if (byte_offset == token_start) begin
                // empty quoted parameter
                error_code_next = tcrt_pkg::ST_WRONG_COUNT;
                phase_next      = tcrt_pkg::PH_SINK;
              end else begin
                push_a           = 1'b1;
                word_a           = span_w;
                params_done_next = 3'(params_done + 1'b1);
                phase_next       = tcrt_pkg::PH_GAP;
              end
            end
          end
          tcrt_pkg::PH_SINK: ;
          default: ;
        endcase
      end
      // offset saturates at the request limit
      if (!too_long) begin
        byte_offset_next = OFF_W'(byte_offset + 1'b1);
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= tcrt_pkg::PH_LEAD;
      byte_offset    <= '0;
      token_start    <= '0;
      name_position  <= '0;
      match_flags    <= '1;
      chosen_command <= '0;
      params_done    <= '0;
      error_code     <= tcrt_pkg::ST_OK;
    end else begin
      phase          <= phase_next;
      byte_offset    <= byte_offset_next;
      token_start    <= token_start_next;
      name_position  <= name_position_next;
      match_flags    <= match_flags_next;
      chosen_command <= chosen_command_next;
      params_done    <= params_done_next;
      error_code     <= error_code_next;
    end
  end

  // Checks
  `TCRT_ASSERT(a_err_only_in_sink, error_code != tcrt_pkg::ST_OK, phase == tcrt_pkg::PH_SINK, "error code held outside sink phase")
  `TCRT_ASSERT(a_pair_from_bare_end, push_b, push_a && cur.is_end && phase == tcrt_pkg::PH_BARE, "word pair outside a bare terminator")
  `TCRT_ASSERT(a_offset_bound, 1'b1, byte_offset <= OFF_W'(MAX_REQUEST_BYTES), "byte offset beyond limit")
  `TCRT_ASSERT_NEXT(a_end_clears, step && cur.is_end, phase == tcrt_pkg::PH_LEAD && byte_offset == '0, "request state not cleared after terminator")

endmodule

`default_nettype wire

>>> test/tb_text_command_request_tokenizer.sv
`default_nettype none

module tb_text_command_request_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcrt_pkg::*;

  localparam int NAME_BYTES     = DEF_NAME_BYTES;
  localparam int MAX_REQ        = DEF_MAX_REQUEST_BYTES;
  localparam int RANDOM_ITEMS   = 320;
  localparam int PHASE_ITEMS    = 50;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // Directed requests; a typed status overrides the predicted one
  localparam int DIR_ROWS      = 14;
  localparam int FIRST_CFG_ROW = 2;
  localparam int PREDICTED     = -1;

  string dir_text [DIR_ROWS] = '{
    "", "get", "", " \t\015\n", "zz", "get", "get k", "set \"\" x", "set \"a b\"c",
    "set a \"bc", "get a b", "abcdefghi", "abcdefgh 1 2 3 4 5 6 7", "\377\200"
  };
  int dir_status [DIR_ROWS] = '{
    ST_UNKNOWN, ST_UNKNOWN, ST_OK, ST_OK, ST_UNKNOWN, ST_WRONG_COUNT, PREDICTED,
    ST_WRONG_COUNT, PREDICTED, ST_WRONG_COUNT, ST_WRONG_COUNT, ST_UNKNOWN, PREDICTED,
    ST_UNKNOWN
  };
  int dir_command [DIR_ROWS] = '{0, 0, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [NAME_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic [7:0]           char_code = '0;
  logic                 out_ready = 1'b0;
  wire logic            in_ready;
  wire logic            out_valid;
  wire logic            kind;
  wire logic [2:0]      param_index;
  wire logic [SPAN_W-1:0] param_start;
  wire logic [SPAN_W-1:0] param_length;
  wire logic [1:0]      status;
  wire logic [1:0]      command;
  wire logic            last;

  text_command_request_tokenizer u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .char_code(char_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .param_index(param_index), .param_start(param_start),
    .param_length(param_length), .status(status), .command(command), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow of the command table
  logic [NAME_W-1:0]   name_tbl [CMD_SLOTS];
  logic [COUNTS_W-1:0] pcount_reg;
  logic [CCOUNT_W-1:0] ccount_reg;

  // Parser state of the predictor
  phase_t      phase;
  logic [12:0] byte_offset;
  logic [12:0] token_start;
  int          name_pos;
  logic [3:0]  match_flags;
  logic [1:0]  chosen;
  int          params_done;
  logic [1:0]  err_code;

  res_t expected_words [$];
  res_t want_word;
  int   mismatches = 0;
  int   items_sent = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  bit   no_idle = 1'b0;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic int params_needed(input logic [1:0] k);
    return int'(pcount_reg[3*k +: 3]);
  endfunction

  function automatic res_t status_word(input logic [1:0] st, input logic [1:0] cmd);
    res_t w;
    w = '0;
    w.kind    = KIND_STATUS;
    w.status  = st;
    w.command = (st == ST_OK) ? cmd : 2'd0;
    w.last    = 1'b1;
    return w;
  endfunction

  task automatic clear_parse_state();
    phase       = PH_LEAD;
    byte_offset = '0;
    token_start = '0;
    name_pos    = 0;
    match_flags = 4'hF;
    chosen      = '0;
    params_done = 0;
    err_code    = ST_OK;
  endtask

  task automatic flag_error(input logic [1:0] e);
    if (err_code == ST_OK) err_code = e;
    phase = PH_SINK;
  endtask

  task automatic match_char(input logic [7:0] c);
    if (name_pos >= NAME_BYTES) begin
      match_flags = '0;
    end else begin
      for (int k = 0; k < CMD_SLOTS; k++)
        if (name_tbl[k][8*name_pos +: 8] != c) match_flags[k] = 1'b0;
      name_pos++;
    end
  endtask

  // End of command word: lowest in-use slot whose name also ends here wins
  function automatic bit word_matches();
    int n;
    n = (ccount_reg > CMD_SLOTS) ? CMD_SLOTS : int'(ccount_reg);
    for (int k = 0; k < n; k++) begin
      if (!match_flags[k]) continue;
      if (name_pos >= NAME_BYTES || name_tbl[k][8*name_pos +: 8] == CH_NUL) begin
        chosen = 2'(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic emit_span(input logic [12:0] len);
    res_t w;
    w = '0;
    w.kind         = KIND_SPAN;
    w.param_index  = 3'(params_done);
    w.param_start  = token_start[SPAN_W-1:0];
    w.param_length = len[SPAN_W-1:0];
    w.command      = chosen;
    expected_words.push_back(w);
    params_done++;
  endtask

  // Advance the predicted parser by one request byte
  task automatic tokenize_byte(input logic [7:0] c);
    logic [12:0] off;
    off = byte_offset;
    if (c == CH_NUL) begin
      case (phase)
        PH_LEAD, PH_WORD: begin
          if (!word_matches()) flag_error(ST_UNKNOWN);
          else if (params_needed(chosen) > 0) flag_error(ST_WRONG_COUNT);
        end
        PH_GAP: if (params_done < params_needed(chosen)) flag_error(ST_WRONG_COUNT);
        PH_BARE: begin
          emit_span(off - token_start);
          if (params_done < params_needed(chosen)) flag_error(ST_WRONG_COUNT);
        end
        PH_QUOTED: flag_error(ST_WRONG_COUNT);
        default: ;
      endcase
      expected_words.push_back(status_word(err_code, chosen));
      clear_parse_state();
    end else begin
      if (phase != PH_SINK && off >= MAX_REQ) flag_error(ST_TOO_LONG);
      else case (phase)
        PH_LEAD: begin
          if (!is_blank(c)) begin
            phase = PH_WORD;
            match_char(c);
          end
        end
        PH_WORD: begin
          if (!is_blank(c)) match_char(c);
          else if (word_matches()) phase = PH_GAP;
          else flag_error(ST_UNKNOWN);
        end
        PH_GAP: begin
          if (!is_blank(c)) begin
            if (params_done >= params_needed(chosen)) begin
              flag_error(ST_WRONG_COUNT);
            end else if (c == CH_QUOTE) begin
              phase = PH_QUOTED;
              token_start = off + 13'd1;
            end else begin
              phase = PH_BARE;
              token_start = off;
            end
          end
        end
        PH_BARE: begin
          if (is_blank(c)) begin
            emit_span(off - token_start);
            phase = PH_GAP;
          end
        end
        PH_QUOTED: begin
          if (c == CH_QUOTE) begin
            if (off == token_start) begin
              flag_error(ST_WRONG_COUNT);
            end else begin
              emit_span(off - token_start);
              phase = PH_GAP;
            end
          end
        end
        default: ;
      endcase
      if (byte_offset < MAX_REQ) byte_offset++;
    end
  endtask

  // Register write, one per cycle; caller lowers cfg_we after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NAME_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_NAME_0, REG_NAME_1, REG_NAME_2, REG_NAME_3: name_tbl[idx[1:0]] = data;
      REG_PARAM_COUNTS: pcount_reg = data[COUNTS_W-1:0];
      REG_CMD_COUNT:    ccount_reg = data[CCOUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one byte, with an optional idle burst first, and wait for the word to go in
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(7) == 0) gap = $urandom_range(17, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= b;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(b);
    items_sent++;
  endtask

  // Hold the sender until every expected word has come out
  task automatic drain_words();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(2));
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [NAME_W-1:0] random_name();
    logic [NAME_W-1:0] v;
    int roll, len;
    v = '0;
    roll = $urandom_range(9);
    if (roll == 1) begin
      v = '1;
    end else if (roll == 2) begin
      v = {$urandom, $urandom};
    end else if (roll > 2) begin
      len = $urandom_range(NAME_BYTES, 1);
      for (int p = 0; p < len; p++) v[8*p +: 8] = letter();
    end
    return v;
  endfunction

  // Table setting per random phase: the first two are the extremes
  task automatic load_random_config(input int p);
    logic [NAME_W-1:0]   filler;
    logic [COUNTS_W-1:0] pc;
    logic [CCOUNT_W-1:0] cnt;
    filler = {$urandom, $urandom};
    if (p == 0) begin
      pc = '0;
      cnt = '0;
    end else if (p == 1) begin
      pc = '1;
      cnt = 3'd4;
    end else begin
      pc = 12'($urandom_range(4095));
      if ($urandom_range(1))
        for (int k = 0; k < CMD_SLOTS; k++) pc[3*k +: 3] = 3'($urandom_range(2));
      cnt = 3'($urandom_range(7));
    end
    for (int k = 0; k < CMD_SLOTS; k++)
      write_reg(REG_NAME_0 + 3'(k), (p == 0) ? '0 : (p == 1) ? '1 : random_name());
    write_reg(REG_PARAM_COUNTS, {filler[NAME_W-1:COUNTS_W], pc});
    write_reg(REG_CMD_COUNT, {filler[NAME_W-1:CCOUNT_W], cnt});
    if ($urandom_range(1)) write_reg(REG_UNUSED_LO, filler);
    if ($urandom_range(1)) write_reg(REG_UNUSED_HI, ~filler);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed requests for a random slot, the rest noise or broken
  task automatic send_random_request();
    logic [7:0] req [$];
    logic [7:0] b;
    int roll, k, nparams, len;
    bit prev_quoted;
    roll = $urandom_range(99);
    if (roll < 15) begin
      len = $urandom_range(12);
      repeat (len) req.push_back(8'($urandom_range(255, 1)));
    end else begin
      k = $urandom_range(CMD_SLOTS - 1);
      nparams = params_needed(2'(k));
      if (roll < 30) nparams = $urandom_range(7);
      repeat ($urandom_range(2)) req.push_back(space_char());
      for (int p = 0; p < NAME_BYTES; p++) begin
        if (name_tbl[k][8*p +: 8] == CH_NUL) break;
        req.push_back(name_tbl[k][8*p +: 8]);
      end
      // word one byte too long
      if (roll >= 30 && roll < 36) req.push_back(letter());
      prev_quoted = 1'b0;
      for (int i = 0; i < nparams; i++) begin
        if (!(prev_quoted && $urandom_range(1)))
          repeat ($urandom_range(2, 1)) req.push_back(space_char());
        if ($urandom_range(1)) begin
          req.push_back(CH_QUOTE);
          len = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
          repeat (len) begin
            b = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) : letter();
            if (b == CH_QUOTE) b = letter();
            req.push_back(b);
          end
          if ($urandom_range(19) != 0) req.push_back(CH_QUOTE);
          prev_quoted = 1'b1;
        end else begin
          repeat ($urandom_range(5, 1)) begin
            b = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 1)) : letter();
            if (is_blank(b)) b = letter();
            req.push_back(b);
          end
          prev_quoted = 1'b0;
        end
      end
      if ($urandom_range(3) == 0) req.push_back(space_char());
    end
    foreach (req[i]) push_byte(req[i]);
    push_byte(CH_NUL);
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Result side: check each accepted word, stall in random bursts
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0d status %0d", $time,
                 kind, status);
        mismatches++;
      end else begin
        want_word = expected_words.pop_front();
        check_field("kind", want_word.kind, kind);
        check_field("param_index", want_word.param_index, param_index);
        check_field("param_start", want_word.param_start, param_start);
        check_field("param_length", want_word.param_length, param_length);
        check_field("status", want_word.status, status);
        check_field("command", want_word.command, command);
        check_field("last", want_word.last, last);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(9) == 0) begin
      stall_left <= $urandom_range(16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: cycles in which no word moves on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < WATCHDOG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int rand_base, phase_base, p;
    for (int k = 0; k < CMD_SLOTS; k++) name_tbl[k] = '0;
    pcount_reg = '0;
    ccount_reg = '0;
    clear_parse_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; the table is loaded once the reset-state rows are done
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == FIRST_CFG_ROW) begin
        drain_words();
        write_reg(REG_NAME_0, 64'h0000_0000_0074_6567);  // get, 1 param
        write_reg(REG_NAME_1, 64'h0000_0000_0074_6573);  // set, 2 params
        write_reg(REG_NAME_2, '0);                       // empty name, none
        write_reg(REG_NAME_3, 64'h6867_6665_6463_6261);  // abcdefgh, 7 params
        write_reg(REG_PARAM_COUNTS, 64'hE11);
        write_reg(REG_CMD_COUNT, 64'd4);
        cfg_we <= 1'b0;
      end
      for (int j = 0; j < dir_text[i].len(); j++) push_byte(dir_text[i][j]);
      push_byte(CH_NUL);
      if (dir_status[i] != PREDICTED)
        expected_words[expected_words.size()-1] =
          status_word(2'(dir_status[i]), 2'(dir_command[i]));
    end

    // Random requests over several table settings
    rand_base = items_sent;
    p = 0;
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      drain_words();
      load_random_config(p);
      p++;
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS && items_sent - rand_base < RANDOM_ITEMS)
      begin
        send_random_request();
        if (items_sent - rand_base >= RANDOM_ITEMS * 7 / 8) no_idle = 1'b1;
        else if ($urandom_range(29) == 0) drain_words();
      end
    end

    drain_words();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
